// File: rtl/core/fpr_pkg.sv
// fpr_pkg: shared types, codes and the byte-wise crc-16/ccitt-false update
// for the framed packet receiver; no dependencies
`default_nettype none

package fpr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned POS_W     = 9;
    localparam int unsigned EVENT_W   = 4;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ACK        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_NACK       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_NOT_CONN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_PING       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_DATA_FRAME = 3'd4;

    // reset values of the command codes
    localparam logic [BYTE_W-1:0] RST_CODE_ACK        = 8'd1;
    localparam logic [BYTE_W-1:0] RST_CODE_NACK       = 8'd2;
    localparam logic [BYTE_W-1:0] RST_CODE_NOT_CONN   = 8'd3;
    localparam logic [BYTE_W-1:0] RST_CODE_PING       = 8'd4;
    localparam logic [BYTE_W-1:0] RST_CODE_DATA_FRAME = 8'd5;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 4'd0,
        EV_PAYLOAD = 4'd1,
        EV_ACK     = 4'd2,
        EV_NACK    = 4'd3,
        EV_NCONN   = 4'd4,
        EV_PING    = 4'd5,
        EV_GOOD    = 4'd6,
        EV_BAD     = 4'd7,
        EV_DROP    = 4'd8
    } t_event;

    typedef struct packed {
        t_event            event_res;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] frame_length;
        logic [BYTE_W-1:0] frame_command;
        logic [CRC_W-1:0]  received_crc;
    } t_result;

    // one byte of crc-16/ccitt-false (poly 0x1021, msb first)
    function automatic logic [CRC_W-1:0] crc16_update(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = {crc[7:0], crc[15:8]};
        c = c ^ {8'h00, data};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fpr_if.sv
// fpr_if: valid/ready channel interfaces for the framed packet receiver
// (received bytes, result items, configuration writes); uses fpr_pkg
`default_nettype none

interface fpr_in_if;
    import fpr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpr_out_if;
    import fpr_pkg::*;
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  payload_byte;
    logic [BYTE_W-1:0]  payload_index;
    logic [BYTE_W-1:0]  frame_length;
    logic [BYTE_W-1:0]  frame_command;
    logic [CRC_W-1:0]   received_crc;
    modport source (output valid, output event_res, output payload_byte,
                    output payload_index, output frame_length,
                    output frame_command, output received_crc, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input payload_index, input frame_length,
                    input frame_command, input received_crc, output ready);
endinterface

interface fpr_cfg_if;
    import fpr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fpr_parser.sv
// fpr_parser: command code registers, frame parse state and running crc;
// produces one result per accepted byte; uses fpr_pkg and fpr_cfg_if
`default_nettype none

module fpr_parser (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    fpr_cfg_if.sink                    i_cfg,
    input  wire logic                  i_push,
    input  wire logic [7:0]            i_rx_byte,
    output fpr_pkg::t_result           o_res
);
    import fpr_pkg::*;

    logic [BYTE_W-1:0] r_code_ack, r_code_nack, r_code_nconn, r_code_ping, r_code_data;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_cmd, n_cmd;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_cnt, n_cnt;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_crc_lo, n_crc_lo;

    logic [POS_W-1:0]  w_pos;
    logic [POS_W-1:0]  w_len;
    logic [CRC_W-1:0]  w_crc_upd;
    logic [CRC_W-1:0]  w_rx_crc;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_ack   <= RST_CODE_ACK;
            r_code_nack  <= RST_CODE_NACK;
            r_code_nconn <= RST_CODE_NOT_CONN;
            r_code_ping  <= RST_CODE_PING;
            r_code_data  <= RST_CODE_DATA_FRAME;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CODE_ACK:        r_code_ack   <= i_cfg.data;
                CFG_CODE_NACK:       r_code_nack  <= i_cfg.data;
                CFG_CODE_NOT_CONN:   r_code_nconn <= i_cfg.data;
                CFG_CODE_PING:       r_code_ping  <= i_cfg.data;
                CFG_CODE_DATA_FRAME: r_code_data  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_pos     = r_pos + POS_W'(1);
    assign w_len     = {1'b0, r_len};
    assign w_crc_upd = crc16_update(r_crc, i_rx_byte);
    assign w_rx_crc  = {i_rx_byte, r_crc_lo};

    always_comb begin
        n_pos    = r_pos;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        o_res    = '0;
        o_res.event_res = EV_NONE;

        if (w_pos == POS_W'(1)) begin
            n_cmd = i_rx_byte;
            n_pos = '0;
            // first match wins when codes coincide
            if (i_rx_byte == r_code_ack) begin
                o_res.event_res = EV_ACK;
            end else if (i_rx_byte == r_code_nack) begin
                o_res.event_res = EV_NACK;
            end else if (i_rx_byte == r_code_nconn) begin
                o_res.event_res = EV_NCONN;
            end else if (i_rx_byte == r_code_ping) begin
                o_res.event_res = EV_PING;
            end else if (i_rx_byte == r_code_data) begin
                n_pos = POS_W'(1);
                n_crc = crc16_update(CRC_INIT, i_rx_byte);
            end else begin
                o_res.event_res = EV_DROP;
            end
        end else if (w_pos == POS_W'(2)) begin
            n_len = i_rx_byte;
            n_crc = w_crc_upd;
            n_pos = POS_W'(2);
        end else if (w_pos <= w_len + POS_W'(2)) begin
            o_res.event_res     = EV_PAYLOAD;
            o_res.payload_byte  = i_rx_byte;
            o_res.payload_index = r_cnt;
            n_cnt = r_cnt + BYTE_W'(1);
            n_crc = w_crc_upd;
            n_pos = w_pos;
        end else if (w_pos == w_len + POS_W'(3)) begin
            n_crc_lo = i_rx_byte;
            n_pos    = w_pos;
        end else begin
            o_res.received_crc = w_rx_crc;
            o_res.event_res    = (w_rx_crc == r_crc) ? EV_GOOD : EV_BAD;
            n_pos = '0;
            n_cnt = '0;
            n_crc = CRC_INIT;
        end

        o_res.frame_length  = n_len;
        o_res.frame_command = n_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_cmd    <= '0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_crc    <= CRC_INIT;
            r_crc_lo <= '0;
        end else if (i_push) begin
            r_pos    <= n_pos;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fpr_out_buf.sv
// fpr_out_buf: result register plus skid register so a byte can be taken
// while a result waits downstream; uses fpr_pkg
`default_nettype none

module fpr_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire fpr_pkg::t_result i_res,
    output logic                  o_push_ready,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output fpr_pkg::t_result      o_res
);
    import fpr_pkg::*;

    logic    r_out_v, n_out_v;
    logic    r_skid_v, n_skid_v;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    assign o_push_ready = !r_skid_v;
    assign o_valid      = r_out_v;
    assign o_res        = r_out;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (r_out_v && !i_ready) begin
            // output stalled: park the new result
            if (i_push) begin
                n_skid   = i_res;
                n_skid_v = 1'b1;
            end
        end else if (r_skid_v) begin
            n_out   = r_skid;
            n_out_v = 1'b1;
            if (i_push) begin
                n_skid = i_res;
            end else begin
                n_skid_v = 1'b0;
            end
        end else begin
            n_out   = i_res;
            n_out_v = i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

// File: rtl/core/framed_packet_receiver_crc16_top.sv
// framed_packet_receiver_crc16_top: top level of the framed packet receiver
// depends on fpr_pkg, fpr_if (channel interfaces), fpr_parser and fpr_out_buf
`default_nettype none

// Takes received serial bytes on i_in, one per transaction, and parses
// messages [command, length, payload, crc low, crc high]. A command byte
// equal to the ack, nack, not-connected or ping code is a whole message on
// its own and gives one event; a data-frame code starts a frame, any other
// code is reported as dropped. Payload bytes come out one by one with their
// index, and the last crc byte reports good or bad for the crc-16/ccitt-false
// (initial 0xffff) over command, length and payload. Every byte gives exactly
// one result transaction on o_out. Throughput is one byte per clock while
// i_in is ready: each byte passes through the parser's next-state logic
// (one byte-wide crc update and the position compares) into the result
// register, or into the skid register behind it while o_out is stalled;
// this keeps i_in ready for one more byte, and i_in drops ready only when
// both the result and skid registers hold results. Command codes are
// written through i_cfg (index 0 ack, 1 nack, 2 not connected, 3 ping,
// 4 data frame), always ready, and should be written only while no message
// is in progress; a write mid-frame takes effect at the next command byte.
module framed_packet_receiver_crc16_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fpr_in_if.sink    i_in,
    fpr_out_if.source o_out,
    fpr_cfg_if.sink   i_cfg
);
    import fpr_pkg::*;

    logic    w_push;
    logic    w_push_ready;
    t_result w_res;
    t_result w_out_res;

    // a byte is taken whenever the skid stage is free
    assign i_in.ready = w_push_ready;
    assign w_push     = i_in.valid && w_push_ready;

    fpr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_push    (w_push),
        .i_rx_byte (i_in.rx_byte),
        .o_res     (w_res)
    );

    fpr_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_res        (w_res),
        .o_push_ready (w_push_ready),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_res        (w_out_res)
    );

    // unpack the result register onto the output channel
    assign o_out.event_res     = w_out_res.event_res;
    assign o_out.payload_byte  = w_out_res.payload_byte;
    assign o_out.payload_index = w_out_res.payload_index;
    assign o_out.frame_length  = w_out_res.frame_length;
    assign o_out.frame_command = w_out_res.frame_command;
    assign o_out.received_crc  = w_out_res.received_crc;

    // an empty result register means nothing is parked, so input is ready
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input not ready with empty output");

    // o_out.valid is high in the cycle after every byte taken
    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> o_out.valid)
        else $error("no result after accepted byte");

    // payload fields are zero outside payload events
    a_payload_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.event_res != EV_PAYLOAD)) |->
            (o_out.payload_byte == '0 && o_out.payload_index == '0))
        else $error("payload fields set outside payload event");

    // received crc only reported with the frame verdict
    a_crc_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.event_res != EV_GOOD && o_out.event_res != EV_BAD)
            |-> (o_out.received_crc == '0))
        else $error("received crc set outside frame end");

endmodule

`default_nettype wire
